FILE: hdl/cpu6502_execute_unit_defines.svh
// assertion macros for the 6502 execute unit
// used by cpu6502_execute_unit.sv, needs a clock named clk and a reset named rst
`ifndef CPU6502_EXECUTE_UNIT_DEFINES_SVH
`define CPU6502_EXECUTE_UNIT_DEFINES_SVH

// same-cycle implication
`define C65_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define C65_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/c65eu_pkg.sv
// shared types and constants for the 6502 execute unit
// no dependencies
package c65eu_pkg;

  localparam int STACK_DEPTH_DEF = 256;

  localparam int FL_C = 0;
  localparam int FL_Z = 1;
  localparam int FL_I = 2;
  localparam int FL_D = 3;
  localparam int FL_V = 6;
  localparam int FL_N = 7;

  localparam logic [7:0] PUSH_P_SET  = 8'h30;
  localparam logic [7:0] PULL_P_MASK = 8'hcf;
  localparam logic [7:0] SP_RESET    = 8'hff;

  typedef enum logic [5:0] {
    OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,
    OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7,
    OP_BNE = 6'd8,  OP_BPL = 6'd9,  OP_BVC = 6'd10, OP_BVS = 6'd11,
    OP_CLC = 6'd12, OP_CLD = 6'd13, OP_CLI = 6'd14, OP_CLV = 6'd15,
    OP_CMP = 6'd16, OP_CPX = 6'd17, OP_CPY = 6'd18, OP_DEC = 6'd19,
    OP_DEX = 6'd20, OP_DEY = 6'd21, OP_EOR = 6'd22, OP_INC = 6'd23,
    OP_INX = 6'd24, OP_INY = 6'd25, OP_JMP = 6'd26, OP_JSR = 6'd27,
    OP_LDA = 6'd28, OP_LDX = 6'd29, OP_LDY = 6'd30, OP_LSR = 6'd31,
    OP_NOP = 6'd32, OP_ORA = 6'd33, OP_PHA = 6'd34, OP_PHP = 6'd35,
    OP_PLA = 6'd36, OP_PLP = 6'd37, OP_ROL = 6'd38, OP_ROR = 6'd39,
    OP_RTI = 6'd40, OP_RTS = 6'd41, OP_SBC = 6'd42, OP_SEC = 6'd43,
    OP_SED = 6'd44, OP_SEI = 6'd45, OP_STA = 6'd46, OP_STX = 6'd47,
    OP_STY = 6'd48, OP_TAX = 6'd49, OP_TAY = 6'd50, OP_TSX = 6'd51,
    OP_TXA = 6'd52, OP_TXS = 6'd53, OP_TYA = 6'd54, OP_NONE = 6'd55
  } op_t;

  typedef struct packed {
    logic [5:0]  req_type;
    logic [7:0]  operand;
    logic [15:0] target_address;
    logic        to_memory;
    logic [1:0]  instr_length;
  } req_t;

  typedef struct packed {
    logic [7:0]  acc_out;
    logic [7:0]  x_out;
    logic [7:0]  y_out;
    logic [7:0]  sp_out;
    logic [7:0]  status_out;
    logic [15:0] pc_out;
    logic        mem_write_valid;
    logic [7:0]  mem_write_data;
    logic        branch_taken;
    logic        crossed_page;
  } rsp_t;

endpackage

FILE: hdl/cpu6502_execute_unit.sv
// 6502 execute unit: registers, alu, branch and stack page in one module
// depends on c65eu_pkg and cpu6502_execute_unit_defines.svh
//
// channel | signals                       | word
// req     | req_valid req_ready req_data  | c65eu_pkg::req_t, one decoded operation
// rsp     | rsp_valid rsp_ready rsp_data  | c65eu_pkg::rsp_t, registers after it
//
// JSR, RTS and RTI take a step for each stack byte, any other op finishes in its first step;
// the stack page memory has one read and one write port, one access per cycle
// reset clears registers and stack valid bits at once, no clearing pass
// a full output register holds the last step of the op in execute and
// blocks req_ready until rsp_ready frees it
`include "cpu6502_execute_unit_defines.svh"

module cpu6502_execute_unit #(
  parameter int STACK_DEPTH = c65eu_pkg::STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  c65eu_pkg::req_t   req_data,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output c65eu_pkg::rsp_t   rsp_data
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // sp mod depth as an elaboration-time table, counted up without division
  typedef logic [AW-1:0] mod_tbl_t [256];

  function automatic mod_tbl_t build_mod_tbl();
    mod_tbl_t tbl;
    int r;
    r = 0;
    for (int i = 0; i < 256; i++) begin
      tbl[i] = AW'(r);
      r = (r + 1 == STACK_DEPTH) ? 0 : r + 1;
    end
    return tbl;
  endfunction

  localparam mod_tbl_t MOD_TBL = build_mod_tbl();

  // architectural registers
  logic [7:0]  a, x, y, sp, p;
  logic [15:0] pc;

  // execute stage
  logic             ex_valid;
  c65eu_pkg::req_t  ex;
  logic [1:0]       step;
  logic [7:0]       tmp;

  // stack page memory and its valid bits
  logic [7:0]             stk_mem [STACK_DEPTH];
  logic [STACK_DEPTH-1:0] stk_vld;
  logic [7:0]             rd_q, fwd_d;
  logic                   rd_vld, fwd_hit;

  // step results
  logic [7:0]  a_next, x_next, y_next, sp_next, p_next, tmp_next;
  logic [15:0] pc_next;
  logic        last, we, wv, taken, crossed;
  logic [7:0]  wd, wdata;
  logic        go, adv, accept;
  logic [7:0]  stk_rd;
  logic [AW-1:0] wa, ra;

  assign go        = !rsp_valid || rsp_ready;
  assign adv       = ex_valid && (!last || go);
  assign req_ready = !ex_valid || (last && go);
  assign accept    = req_valid && req_ready;

  // byte just read from the stack, with bypass of last cycle's write
  assign stk_rd = fwd_hit ? fwd_d : (rd_vld ? rd_q : 8'h00);

  always_comb begin
    logic [7:0]  v, r, cmp_reg;
    logic [8:0]  t;
    logic [7:0]  m;
    logic [15:0] seq, dest, ret;
    logic        cond, is_br, modify, do_cmp;
    logic [2:0]  kind;
    a_next   = a;
    x_next   = x;
    y_next   = y;
    sp_next  = sp;
    p_next   = p;
    tmp_next = tmp;
    seq      = pc + {14'd0, ex.instr_length};
    pc_next  = (ex.req_type > c65eu_pkg::OP_TYA) ? pc : seq;
    last     = 1'b1;
    we       = 1'b0;
    wd       = 8'h00;
    wv       = 1'b0;
    wdata    = 8'h00;
    taken    = 1'b0;
    crossed  = 1'b0;
    cond     = 1'b0;
    is_br    = 1'b0;
    modify   = 1'b0;
    do_cmp   = 1'b0;
    kind     = 3'd0;
    cmp_reg  = a;
    m        = ex.operand;
    ret      = seq - 16'd1;
    v        = 8'h00;
    r        = 8'h00;
    t        = 9'd0;
    dest     = 16'd0;

    case (c65eu_pkg::op_t'(ex.req_type))
      c65eu_pkg::OP_ADC, c65eu_pkg::OP_SBC: begin
        if (ex.req_type == c65eu_pkg::OP_SBC) m = ~ex.operand;
        t = {1'b0, a} + {1'b0, m} + {8'd0, p[c65eu_pkg::FL_C]};
        p_next[c65eu_pkg::FL_C] = t[8];
        p_next[c65eu_pkg::FL_V] = (a[7] ^ t[7]) & (m[7] ^ t[7]);
        a_next = t[7:0];
      end
      c65eu_pkg::OP_AND: a_next = a & ex.operand;
      c65eu_pkg::OP_EOR: a_next = a ^ ex.operand;
      c65eu_pkg::OP_ORA: a_next = a | ex.operand;
      c65eu_pkg::OP_ASL: begin modify = 1'b1; kind = 3'd0; end
      c65eu_pkg::OP_LSR: begin modify = 1'b1; kind = 3'd1; end
      c65eu_pkg::OP_ROL: begin modify = 1'b1; kind = 3'd2; end
      c65eu_pkg::OP_ROR: begin modify = 1'b1; kind = 3'd3; end
      c65eu_pkg::OP_INC: begin modify = 1'b1; kind = 3'd4; end
      c65eu_pkg::OP_DEC: begin modify = 1'b1; kind = 3'd5; end
      c65eu_pkg::OP_BCC: begin is_br = 1'b1; cond = !p[c65eu_pkg::FL_C]; end
      c65eu_pkg::OP_BCS: begin is_br = 1'b1; cond =  p[c65eu_pkg::FL_C]; end
      c65eu_pkg::OP_BEQ: begin is_br = 1'b1; cond =  p[c65eu_pkg::FL_Z]; end
      c65eu_pkg::OP_BNE: begin is_br = 1'b1; cond = !p[c65eu_pkg::FL_Z]; end
      c65eu_pkg::OP_BMI: begin is_br = 1'b1; cond =  p[c65eu_pkg::FL_N]; end
      c65eu_pkg::OP_BPL: begin is_br = 1'b1; cond = !p[c65eu_pkg::FL_N]; end
      c65eu_pkg::OP_BVC: begin is_br = 1'b1; cond = !p[c65eu_pkg::FL_V]; end
      c65eu_pkg::OP_BVS: begin is_br = 1'b1; cond =  p[c65eu_pkg::FL_V]; end
      c65eu_pkg::OP_BIT: begin
        p_next[c65eu_pkg::FL_Z] = (a & ex.operand) == 8'h00;
        p_next[c65eu_pkg::FL_V] = ex.operand[6];
        p_next[c65eu_pkg::FL_N] = ex.operand[7];
      end
      c65eu_pkg::OP_CLC: p_next[c65eu_pkg::FL_C] = 1'b0;
      c65eu_pkg::OP_CLD: p_next[c65eu_pkg::FL_D] = 1'b0;
      c65eu_pkg::OP_CLI: p_next[c65eu_pkg::FL_I] = 1'b0;
      c65eu_pkg::OP_CLV: p_next[c65eu_pkg::FL_V] = 1'b0;
      c65eu_pkg::OP_SEC: p_next[c65eu_pkg::FL_C] = 1'b1;
      c65eu_pkg::OP_SED: p_next[c65eu_pkg::FL_D] = 1'b1;
      c65eu_pkg::OP_SEI: p_next[c65eu_pkg::FL_I] = 1'b1;
      c65eu_pkg::OP_CMP: begin do_cmp = 1'b1; cmp_reg = a; end
      c65eu_pkg::OP_CPX: begin do_cmp = 1'b1; cmp_reg = x; end
      c65eu_pkg::OP_CPY: begin do_cmp = 1'b1; cmp_reg = y; end
      c65eu_pkg::OP_DEX: x_next = x - 8'd1;
      c65eu_pkg::OP_DEY: y_next = y - 8'd1;
      c65eu_pkg::OP_INX: x_next = x + 8'd1;
      c65eu_pkg::OP_INY: y_next = y + 8'd1;
      c65eu_pkg::OP_JMP: pc_next = ex.target_address;
      c65eu_pkg::OP_JSR: begin
        // high byte of the return address first, then the low byte
        we      = 1'b1;
        wd      = (step == 2'd0) ? ret[15:8] : ret[7:0];
        sp_next = sp - 8'd1;
        last    = (step != 2'd0);
        pc_next = ex.target_address;
      end
      c65eu_pkg::OP_LDA: a_next = ex.operand;
      c65eu_pkg::OP_LDX: x_next = ex.operand;
      c65eu_pkg::OP_LDY: y_next = ex.operand;
      c65eu_pkg::OP_PHA: begin we = 1'b1; wd = a; sp_next = sp - 8'd1; end
      c65eu_pkg::OP_PHP: begin
        we = 1'b1; wd = p | c65eu_pkg::PUSH_P_SET; sp_next = sp - 8'd1;
      end
      c65eu_pkg::OP_PLA: begin a_next = stk_rd; sp_next = sp + 8'd1; end
      c65eu_pkg::OP_PLP: begin
        p_next = stk_rd & c65eu_pkg::PULL_P_MASK; sp_next = sp + 8'd1;
      end
      c65eu_pkg::OP_RTS: begin
        sp_next  = sp + 8'd1;
        tmp_next = stk_rd;
        last     = (step != 2'd0);
        pc_next  = {stk_rd, tmp} + 16'd1;
      end
      c65eu_pkg::OP_RTI: begin
        sp_next  = sp + 8'd1;
        tmp_next = stk_rd;
        last     = (step == 2'd2);
        if (step == 2'd0) p_next = stk_rd & c65eu_pkg::PULL_P_MASK;
        pc_next  = {stk_rd, tmp};
      end
      c65eu_pkg::OP_STA: begin wv = 1'b1; wdata = a; end
      c65eu_pkg::OP_STX: begin wv = 1'b1; wdata = x; end
      c65eu_pkg::OP_STY: begin wv = 1'b1; wdata = y; end
      c65eu_pkg::OP_TAX: x_next = a;
      c65eu_pkg::OP_TAY: y_next = a;
      c65eu_pkg::OP_TSX: x_next = sp;
      c65eu_pkg::OP_TXA: a_next = x;
      c65eu_pkg::OP_TXS: sp_next = x;
      c65eu_pkg::OP_TYA: a_next = y;
      default: ;
    endcase

    // nz from whichever register the op loads
    case (c65eu_pkg::op_t'(ex.req_type))
      c65eu_pkg::OP_ADC, c65eu_pkg::OP_SBC, c65eu_pkg::OP_AND, c65eu_pkg::OP_EOR,
      c65eu_pkg::OP_ORA, c65eu_pkg::OP_LDA, c65eu_pkg::OP_PLA, c65eu_pkg::OP_TXA,
      c65eu_pkg::OP_TYA: begin
        p_next[c65eu_pkg::FL_Z] = a_next == 8'h00;
        p_next[c65eu_pkg::FL_N] = a_next[7];
      end
      c65eu_pkg::OP_DEX, c65eu_pkg::OP_INX, c65eu_pkg::OP_LDX, c65eu_pkg::OP_TAX,
      c65eu_pkg::OP_TSX: begin
        p_next[c65eu_pkg::FL_Z] = x_next == 8'h00;
        p_next[c65eu_pkg::FL_N] = x_next[7];
      end
      c65eu_pkg::OP_DEY, c65eu_pkg::OP_INY, c65eu_pkg::OP_LDY, c65eu_pkg::OP_TAY: begin
        p_next[c65eu_pkg::FL_Z] = y_next == 8'h00;
        p_next[c65eu_pkg::FL_N] = y_next[7];
      end
      default: ;
    endcase

    if (do_cmp) begin
      p_next[c65eu_pkg::FL_C] = cmp_reg >= ex.operand;
      p_next[c65eu_pkg::FL_Z] = cmp_reg == ex.operand;
      p_next[c65eu_pkg::FL_N] = 8'(cmp_reg - ex.operand) >> 7 != 8'd0;
    end

    if (modify) begin
      v = ex.to_memory ? ex.operand : a;
      case (kind)
        3'd0: begin r = {v[6:0], 1'b0}; p_next[c65eu_pkg::FL_C] = v[7]; end
        3'd1: begin r = {1'b0, v[7:1]}; p_next[c65eu_pkg::FL_C] = v[0]; end
        3'd2: begin
          r = {v[6:0], p[c65eu_pkg::FL_C]}; p_next[c65eu_pkg::FL_C] = v[7];
        end
        3'd3: begin
          r = {p[c65eu_pkg::FL_C], v[7:1]}; p_next[c65eu_pkg::FL_C] = v[0];
        end
        3'd4:    r = v + 8'd1;
        default: r = v - 8'd1;
      endcase
      p_next[c65eu_pkg::FL_Z] = r == 8'h00;
      p_next[c65eu_pkg::FL_N] = r[7];
      if (ex.to_memory) begin
        wv    = 1'b1;
        wdata = r;
      end else begin
        a_next = r;
      end
    end

    if (is_br && cond) begin
      dest    = seq + {{8{ex.operand[7]}}, ex.operand};
      taken   = 1'b1;
      crossed = dest[15:8] != seq[15:8];
      pc_next = dest;
    end
  end

  // push writes at sp, next read looks at the byte above the new sp
  assign wa = MOD_TBL[sp];
  assign ra = MOD_TBL[8'((adv ? sp_next : sp) + 8'd1)];

  always_ff @(posedge clk) begin
    if (adv && we) stk_mem[wa] <= wd;
    rd_q    <= stk_mem[ra];
    fwd_hit <= adv && we && (wa == ra);
    fwd_d   <= wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stk_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (adv && we) stk_vld[wa] <= 1'b1;
      rd_vld <= stk_vld[ra];
    end
  end

  // architectural state and execute stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a        <= 8'h00;
      x        <= 8'h00;
      y        <= 8'h00;
      sp       <= c65eu_pkg::SP_RESET;
      p        <= 8'h00;
      pc       <= 16'h0000;
      ex_valid <= 1'b0;
      step     <= 2'd0;
    end else begin
      if (adv) begin
        a  <= a_next;
        x  <= x_next;
        y  <= y_next;
        sp <= sp_next;
        p  <= p_next;
        if (last) pc <= pc_next;
        step <= last ? 2'd0 : step + 2'd1;
      end
      if (accept) ex_valid <= 1'b1;
      else if (adv && last) ex_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) ex <= req_data;
    if (adv) tmp <= tmp_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv && last) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && last) begin
      rsp_data.acc_out         <= a_next;
      rsp_data.x_out           <= x_next;
      rsp_data.y_out           <= y_next;
      rsp_data.sp_out          <= sp_next;
      rsp_data.status_out      <= p_next;
      rsp_data.pc_out          <= pc_next;
      rsp_data.mem_write_valid <= wv;
      rsp_data.mem_write_data  <= wdata;
      rsp_data.branch_taken    <= taken;
      rsp_data.crossed_page    <= crossed;
    end
  end

  // a new word only enters a busy stage when the op in execute finishes this cycle
  `C65_ASSERT_NOW(a_accept_free, accept && ex_valid, last && go, "accept over busy stage")
  // a partly done op is always held in execute
  `C65_ASSERT_NOW(a_step_held, step != 2'd0, ex_valid, "step count without op")
  // finishing an op fills the output register
  `C65_ASSERT_NEXT(a_finish_out, adv && last, rsp_valid, "finished op lost")
  // page cross only comes with a taken branch
  `C65_ASSERT_NOW(a_cross_taken, rsp_valid && rsp_data.crossed_page,
                  rsp_data.branch_taken, "page cross without branch")

endmodule

FILE: tb/sv/cpu6502_execute_unit_test.sv
// testbench for cpu6502_execute_unit: directed table then random operations
// depends on c65eu_pkg and the execute unit rtl; self-checking against its own register model
`timescale 1ns / 100ps

module cpu6502_execute_unit_test;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  c65eu_pkg::req_t req_data;
  logic rsp_valid;
  logic rsp_ready;
  c65eu_pkg::rsp_t rsp_data;

  cpu6502_execute_unit dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // register file mirror of the cpu
  logic [7:0]  m_a, m_x, m_y, m_sp, m_p;
  logic [15:0] m_pc;
  logic [7:0]  m_stack [256];

  c65eu_pkg::rsp_t expected_words[$];
  int   errors;
  int   cycle_count;
  bit   idle_free;       // long stretch with no idling on either side

  function automatic void set_nz(input logic [7:0] v);
    m_p[c65eu_pkg::FL_Z] = (v == 8'h00);
    m_p[c65eu_pkg::FL_N] = v[7];
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    m_stack[m_sp] = b;
    m_sp = m_sp - 8'd1;
  endfunction

  function automatic logic [7:0] pull_byte();
    m_sp = m_sp + 8'd1;
    return m_stack[m_sp];
  endfunction

  function automatic void add_with_carry(input logic [7:0] m);
    logic [8:0] t;
    t = {1'b0, m_a} + {1'b0, m} + {8'd0, m_p[c65eu_pkg::FL_C]};
    m_p[c65eu_pkg::FL_C] = t[8];
    m_p[c65eu_pkg::FL_V] = ((m_a ^ t[7:0]) & (m ^ t[7:0]) & 8'h80) != 8'h00;
    m_a = t[7:0];
    set_nz(m_a);
  endfunction

  function automatic void compare_reg(input logic [7:0] r, input logic [7:0] m);
    logic [7:0] d;
    d = r - m;
    m_p[c65eu_pkg::FL_C] = (r >= m);
    m_p[c65eu_pkg::FL_Z] = (r == m);
    m_p[c65eu_pkg::FL_N] = d[7];
  endfunction

  function automatic logic [7:0] modify_byte(input c65eu_pkg::op_t op,
                                             input logic [7:0] v);
    logic       cin;
    logic [7:0] r;
    cin = m_p[c65eu_pkg::FL_C];
    case (op)
      c65eu_pkg::OP_ASL: begin m_p[c65eu_pkg::FL_C] = v[7]; r = {v[6:0], 1'b0}; end
      c65eu_pkg::OP_LSR: begin m_p[c65eu_pkg::FL_C] = v[0]; r = {1'b0, v[7:1]}; end
      c65eu_pkg::OP_ROL: begin m_p[c65eu_pkg::FL_C] = v[7]; r = {v[6:0], cin}; end
      c65eu_pkg::OP_ROR: begin m_p[c65eu_pkg::FL_C] = v[0]; r = {cin, v[7:1]}; end
      c65eu_pkg::OP_INC: r = v + 8'd1;
      default: r = v - 8'd1;
    endcase
    set_nz(r);
    return r;
  endfunction

  // executes one operation on the mirror and returns the register word
  function automatic c65eu_pkg::rsp_t execute_op(input c65eu_pkg::req_t rq);
    c65eu_pkg::rsp_t w;
    c65eu_pkg::op_t  op;
    logic [15:0] nxt, ret, dest;
    logic [7:0]  lo, hi;
    logic        cond;
    logic        wv, taken, crossed;
    logic [7:0]  wd;
    op = c65eu_pkg::op_t'(rq.req_type);
    nxt = m_pc + {14'd0, rq.instr_length};
    if (rq.req_type > c65eu_pkg::OP_TYA) nxt = m_pc;
    cond = 1'b0;
    wv = 1'b0; wd = 8'h00; taken = 1'b0; crossed = 1'b0;
    case (op)
      c65eu_pkg::OP_ADC: add_with_carry(rq.operand);
      c65eu_pkg::OP_SBC: add_with_carry(~rq.operand);
      c65eu_pkg::OP_AND: begin m_a = m_a & rq.operand; set_nz(m_a); end
      c65eu_pkg::OP_EOR: begin m_a = m_a ^ rq.operand; set_nz(m_a); end
      c65eu_pkg::OP_ORA: begin m_a = m_a | rq.operand; set_nz(m_a); end
      c65eu_pkg::OP_ASL, c65eu_pkg::OP_LSR, c65eu_pkg::OP_ROL, c65eu_pkg::OP_ROR,
      c65eu_pkg::OP_INC, c65eu_pkg::OP_DEC: begin
        if (rq.to_memory) begin
          wv = 1'b1;
          wd = modify_byte(op, rq.operand);
        end else begin
          m_a = modify_byte(op, m_a);
        end
      end
      c65eu_pkg::OP_BCC: cond = !m_p[c65eu_pkg::FL_C];
      c65eu_pkg::OP_BCS: cond = m_p[c65eu_pkg::FL_C];
      c65eu_pkg::OP_BEQ: cond = m_p[c65eu_pkg::FL_Z];
      c65eu_pkg::OP_BNE: cond = !m_p[c65eu_pkg::FL_Z];
      c65eu_pkg::OP_BMI: cond = m_p[c65eu_pkg::FL_N];
      c65eu_pkg::OP_BPL: cond = !m_p[c65eu_pkg::FL_N];
      c65eu_pkg::OP_BVS: cond = m_p[c65eu_pkg::FL_V];
      c65eu_pkg::OP_BVC: cond = !m_p[c65eu_pkg::FL_V];
      c65eu_pkg::OP_BIT: begin
        m_p[c65eu_pkg::FL_Z] = (m_a & rq.operand) == 8'h00;
        m_p[c65eu_pkg::FL_V] = rq.operand[6];
        m_p[c65eu_pkg::FL_N] = rq.operand[7];
      end
      c65eu_pkg::OP_CLC: m_p[c65eu_pkg::FL_C] = 1'b0;
      c65eu_pkg::OP_CLD: m_p[c65eu_pkg::FL_D] = 1'b0;
      c65eu_pkg::OP_CLI: m_p[c65eu_pkg::FL_I] = 1'b0;
      c65eu_pkg::OP_CLV: m_p[c65eu_pkg::FL_V] = 1'b0;
      c65eu_pkg::OP_SEC: m_p[c65eu_pkg::FL_C] = 1'b1;
      c65eu_pkg::OP_SED: m_p[c65eu_pkg::FL_D] = 1'b1;
      c65eu_pkg::OP_SEI: m_p[c65eu_pkg::FL_I] = 1'b1;
      c65eu_pkg::OP_CMP: compare_reg(m_a, rq.operand);
      c65eu_pkg::OP_CPX: compare_reg(m_x, rq.operand);
      c65eu_pkg::OP_CPY: compare_reg(m_y, rq.operand);
      c65eu_pkg::OP_DEX: begin m_x = m_x - 8'd1; set_nz(m_x); end
      c65eu_pkg::OP_DEY: begin m_y = m_y - 8'd1; set_nz(m_y); end
      c65eu_pkg::OP_INX: begin m_x = m_x + 8'd1; set_nz(m_x); end
      c65eu_pkg::OP_INY: begin m_y = m_y + 8'd1; set_nz(m_y); end
      c65eu_pkg::OP_JMP: nxt = rq.target_address;
      c65eu_pkg::OP_JSR: begin
        ret = nxt - 16'd1;
        push_byte(ret[15:8]);
        push_byte(ret[7:0]);
        nxt = rq.target_address;
      end
      c65eu_pkg::OP_LDA: begin m_a = rq.operand; set_nz(m_a); end
      c65eu_pkg::OP_LDX: begin m_x = rq.operand; set_nz(m_x); end
      c65eu_pkg::OP_LDY: begin m_y = rq.operand; set_nz(m_y); end
      c65eu_pkg::OP_PHA: push_byte(m_a);
      c65eu_pkg::OP_PHP: push_byte(m_p | c65eu_pkg::PUSH_P_SET);
      c65eu_pkg::OP_PLA: begin m_a = pull_byte(); set_nz(m_a); end
      c65eu_pkg::OP_PLP: m_p = pull_byte() & c65eu_pkg::PULL_P_MASK;
      c65eu_pkg::OP_RTI: begin
        m_p = pull_byte() & c65eu_pkg::PULL_P_MASK;
        lo = pull_byte();
        hi = pull_byte();
        nxt = {hi, lo};
      end
      c65eu_pkg::OP_RTS: begin
        lo = pull_byte();
        hi = pull_byte();
        nxt = {hi, lo} + 16'd1;
      end
      c65eu_pkg::OP_STA: begin wv = 1'b1; wd = m_a; end
      c65eu_pkg::OP_STX: begin wv = 1'b1; wd = m_x; end
      c65eu_pkg::OP_STY: begin wv = 1'b1; wd = m_y; end
      c65eu_pkg::OP_TAX: begin m_x = m_a; set_nz(m_x); end
      c65eu_pkg::OP_TAY: begin m_y = m_a; set_nz(m_y); end
      c65eu_pkg::OP_TSX: begin m_x = m_sp; set_nz(m_x); end
      c65eu_pkg::OP_TXA: begin m_a = m_x; set_nz(m_a); end
      c65eu_pkg::OP_TXS: m_sp = m_x;
      c65eu_pkg::OP_TYA: begin m_a = m_y; set_nz(m_a); end
      default: ;
    endcase
    if (cond) begin
      dest = nxt + {{8{rq.operand[7]}}, rq.operand};
      taken = 1'b1;
      crossed = dest[15:8] != nxt[15:8];
      nxt = dest;
    end
    m_pc = nxt;
    w.acc_out = m_a;
    w.x_out = m_x;
    w.y_out = m_y;
    w.sp_out = m_sp;
    w.status_out = m_p;
    w.pc_out = m_pc;
    w.mem_write_valid = wv;
    w.mem_write_data = wd;
    w.branch_taken = taken;
    w.crossed_page = crossed;
    return w;
  endfunction

  // directed table; typed results are checked against the mirror too
  typedef struct {
    c65eu_pkg::req_t rq;
    bit              typed;
    c65eu_pkg::rsp_t want;
  } vector_t;
  vector_t vectors[$];

  function automatic c65eu_pkg::req_t make_req(input c65eu_pkg::op_t op,
                                               input logic [7:0] opnd,
                                               input logic [15:0] tgt, input logic mem,
                                               input logic [1:0] len);
    c65eu_pkg::req_t r;
    r.req_type = op;
    r.operand = opnd;
    r.target_address = tgt;
    r.to_memory = mem;
    r.instr_length = len;
    return r;
  endfunction

  function automatic void add_vec(input c65eu_pkg::req_t rq);
    vector_t v;
    v.rq = rq;
    v.typed = 1'b0;
    v.want = '0;
    vectors.push_back(v);
  endfunction

  function automatic void add_typed(input c65eu_pkg::req_t rq, input c65eu_pkg::rsp_t want);
    vector_t v;
    v.rq = rq;
    v.typed = 1'b1;
    v.want = want;
    vectors.push_back(v);
  endfunction

  function automatic void build_table();
    c65eu_pkg::rsp_t w;
    // nop right after reset: registers at reset, pc advanced by one
    w = '0;
    w.sp_out = c65eu_pkg::SP_RESET;
    w.pc_out = 16'd1;
    add_typed(make_req(c65eu_pkg::OP_NOP, 8'hff, 16'hffff, 1'b1, 2'd1), w);
    // unused code: nothing changes, pc not advanced
    add_typed(make_req(c65eu_pkg::op_t'(6'd63), 8'hff, 16'hffff, 1'b1, 2'd3), w);
    // load of the all-ones byte
    w.acc_out = 8'hff;
    w.status_out = 8'h80;
    w.pc_out = 16'd3;
    add_typed(make_req(c65eu_pkg::OP_LDA, 8'hff, 16'h0000, 1'b0, 2'd2), w);
    add_vec(make_req(c65eu_pkg::OP_ADC, 8'h01, 16'h0000, 1'b0, 2'd2));   // carry out, zero
    add_vec(make_req(c65eu_pkg::OP_ADC, 8'h7f, 16'h0000, 1'b0, 2'd2));   // signed overflow
    add_vec(make_req(c65eu_pkg::OP_SBC, 8'hff, 16'h0000, 1'b0, 2'd2));
    add_vec(make_req(c65eu_pkg::OP_CMP, 8'h80, 16'h0000, 1'b0, 2'd2));   // reg equal to operand
    add_vec(make_req(c65eu_pkg::OP_CPX, 8'h00, 16'h0000, 1'b0, 2'd2));   // equal
    add_vec(make_req(c65eu_pkg::OP_ASL, 8'h81, 16'h0000, 1'b1, 2'd3));
    add_vec(make_req(c65eu_pkg::OP_ROR, 8'h01, 16'h0000, 1'b0, 2'd1));
    add_vec(make_req(c65eu_pkg::OP_DEC, 8'h00, 16'h0000, 1'b1, 2'd2));
    add_vec(make_req(c65eu_pkg::OP_JMP, 8'h00, 16'hfffe, 1'b0, 2'd3));
    add_vec(make_req(c65eu_pkg::OP_BNE, 8'h7f, 16'h0000, 1'b0, 2'd2));   // forward, taken, no page cross
    add_vec(make_req(c65eu_pkg::OP_BEQ, 8'h80, 16'h0000, 1'b0, 2'd2));
    add_vec(make_req(c65eu_pkg::OP_JSR, 8'h00, 16'hffff, 1'b0, 2'd3));
    add_vec(make_req(c65eu_pkg::OP_RTS, 8'h00, 16'h0000, 1'b0, 2'd1));
    add_vec(make_req(c65eu_pkg::OP_PHP, 8'h00, 16'h0000, 1'b0, 2'd1));
    add_vec(make_req(c65eu_pkg::OP_PHA, 8'h00, 16'h0000, 1'b0, 2'd1));
    add_vec(make_req(c65eu_pkg::OP_JSR, 8'h00, 16'h1234, 1'b0, 2'd0));   // zero length
    add_vec(make_req(c65eu_pkg::OP_PHP, 8'h00, 16'h0000, 1'b0, 2'd1));
    add_vec(make_req(c65eu_pkg::OP_RTI, 8'h00, 16'h0000, 1'b0, 2'd1));
    add_vec(make_req(c65eu_pkg::OP_PLA, 8'h00, 16'h0000, 1'b0, 2'd1));
    add_vec(make_req(c65eu_pkg::OP_PLP, 8'h00, 16'h0000, 1'b0, 2'd1));
    add_vec(make_req(c65eu_pkg::OP_TSX, 8'h00, 16'h0000, 1'b0, 2'd1));
    add_vec(make_req(c65eu_pkg::OP_STX, 8'h00, 16'h0000, 1'b0, 2'd2));
  endfunction

  // random operation; stack ops weighted up, some unused codes
  function automatic c65eu_pkg::req_t random_req();
    c65eu_pkg::req_t r;
    int   pick;
    r.operand = 8'($urandom_range(255, 0));
    r.target_address = 16'($urandom_range(65535, 0));
    r.to_memory = 1'($urandom_range(1, 0));
    r.instr_length = 2'($urandom_range(3, 0));
    pick = $urandom_range(99, 0);
    if (pick < 4) r.req_type = 6'($urandom_range(63, 55));
    else if (pick < 24) begin
      case ($urandom_range(7, 0))
        0: r.req_type = c65eu_pkg::OP_JSR;
        1: r.req_type = c65eu_pkg::OP_RTS;
        2: r.req_type = c65eu_pkg::OP_RTI;
        3: r.req_type = c65eu_pkg::OP_PHA;
        4: r.req_type = c65eu_pkg::OP_PHP;
        5: r.req_type = c65eu_pkg::OP_PLA;
        6: r.req_type = c65eu_pkg::OP_PLP;
        default: r.req_type = c65eu_pkg::OP_TXS;
      endcase
    end else r.req_type = 6'($urandom_range(54, 0));
    return r;
  endfunction

  // sends one word, idling before it at random
  task automatic send_word(input c65eu_pkg::req_t rq);
    while (!idle_free && $urandom_range(99, 0) < 34) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= rq;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    expected_words.push_back(execute_op(rq));
  endtask

  // receiver: random stall on rsp_ready, word check on each acceptance
  always @(posedge clk) begin
    c65eu_pkg::rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word %h", $time, rsp_data);
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (rsp_data !== want) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, rsp_data);
            errors++;
          end
        end
      end
      rsp_ready <= idle_free || ($urandom_range(99, 0) >= 34);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 200000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cycle_count = 0;
    idle_free = 1'b0;
    rst = 1'b1;
    req_valid = 1'b0;
    req_data = '0;
    m_a = 8'h00; m_x = 8'h00; m_y = 8'h00;
    m_sp = c65eu_pkg::SP_RESET; m_p = 8'h00; m_pc = 16'h0000;
    for (int i = 0; i < 256; i++) m_stack[i] = 8'h00;
    build_table();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (vectors[i]) begin
      send_word(vectors[i].rq);
      if (vectors[i].typed && expected_words[$] !== vectors[i].want) begin
        $display("%0t: table row %0d expected %h actual %h", $time, i,
                 vectors[i].want, expected_words[$]);
        errors++;
      end
    end
    req_valid <= 1'b0;

    // hold off until everything is drained
    while (expected_words.size() != 0) @(posedge clk);

    // random part, with a stretch that never idles
    for (int n = 0; n < 1350; n++) begin
      idle_free = (n >= 500 && n < 700);
      send_word(random_req());
    end
    req_valid <= 1'b0;
    idle_free = 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/c65eu_pkg.sv
hdl/cpu6502_execute_unit.sv
tb/sv/cpu6502_execute_unit_test.sv
